// ===== hw/rtl/cg4_pkg.sv =====
package cg4_pkg;

  // Depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Register indexes on the config port
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [12:0] HEIGHT_MIN   = 13'd3;
  localparam logic [12:0] HEIGHT_MAX   = 13'd4096;

  // Direction codes
  localparam logic [2:0] DIR_HORZ = 3'd0;
  localparam logic [2:0] DIR_DIAG = 3'd1;
  localparam logic [2:0] DIR_VERT = 3'd6;
  localparam logic [2:0] DIR_ANTI = 3'd7;

  // x/3 == (x*683)>>11 for x in 0..765
  localparam logic [19:0] DIV3_RECIP = 20'd683;

  typedef struct packed {
    logic main;      // result for (r-1, c-1)
    logic interior;  // that result has a full window
    logic side;      // right border result for (r-1, W-1)
    logic bottom;    // bottom row result for (r, c)
    logic last;      // last pixel of frame
  } cg4_flags_t;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    cg4_flags_t  flags;
  } cg4_tag_t;

  typedef struct packed {
    logic [7:0] tl;
    logic [7:0] ml;
    logic [7:0] bl;
    logic [7:0] tm;
    logic [7:0] bm;
    logic [7:0] tr;
    logic [7:0] mr;
    logic [7:0] br;
    cg4_tag_t   tag;
  } cg4_item_t;

  typedef struct packed {
    logic [9:0] gx;
    logic [9:0] gd;
    logic [9:0] gy;
    logic [9:0] gi;
  } cg4_grad_t;

  typedef struct packed {
    logic [7:0] qx;
    logic [7:0] qd;
    logic [7:0] qy;
    logic [7:0] qi;
  } cg4_quot_t;

  function automatic logic [9:0] sum3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return 10'(a) + 10'(b) + 10'(c);
  endfunction

  function automatic logic [9:0] absdiff(input logic [9:0] p, input logic [9:0] n);
    return (p >= n) ? (p - n) : (n - p);
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] a);
    logic [19:0] prod;
    prod = 20'(a) * DIV3_RECIP;
    return prod[18:11];
  endfunction

endpackage

// ===== hw/rtl/cg4_front.sv =====
module cg4_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [12:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_pixel,
  input  logic [cg4_pkg::QCW-1:0] q_count,
  output logic                   q_push,
  output cg4_pkg::cg4_item_t     q_item
);
  import cg4_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > 11) ? WW : 11;

  logic [10:0]   width_r;
  logic [12:0]   height_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic          s1_valid_r;
  logic [7:0]    s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic [11:0]   s1_row_r;
  cg4_flags_t    s1_flags_r;
  cg4_flags_t    flags_now;
  logic [7:0]    up_rd_r, md_rd_r;
  logic [7:0]    win_r [6];
  logic [7:0]    upper_mem [MAX_WIDTH];
  logic [7:0]    middle_mem [MAX_WIDTH];

  logic [EW-1:0] w_ext, w_cl;
  logic [CW-1:0] wm1;
  logic [12:0]   h_cl;
  logic [11:0]   hm1;
  logic          wrap;
  logic [CW-1:0] c_now;
  logic [11:0]   r_now;
  logic          acc;

  // width/height in effect
  always_comb begin
    w_ext = EW'(width_r);
    if (w_ext < EW'(3)) begin
      w_cl = EW'(3);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_cl = EW'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    wm1 = CW'(w_cl - EW'(1));
    if (height_r < HEIGHT_MIN) begin
      h_cl = HEIGHT_MIN;
    end else if (height_r > HEIGHT_MAX) begin
      h_cl = HEIGHT_MAX;
    end else begin
      h_cl = height_r;
    end
    hm1 = 12'(h_cl - 13'd1);
  end

  assign in_stall = (q_count + QCW'(s1_valid_r)) >= QCW'(QDEPTH);
  assign acc      = in_valid && !in_stall;

  // position of the incoming pixel; restart the frame if sizes shrank
  assign wrap  = (col_r > wm1) || (row_r > hm1);
  assign c_now = wrap ? '0 : col_r;
  assign r_now = wrap ? '0 : row_r;

  always_comb begin
    flags_now.main     = (r_now != '0) && (c_now != '0);
    flags_now.interior = (r_now >= 12'd2) && (c_now >= CW'(2));
    flags_now.side     = (r_now != '0) && (c_now == wm1);
    flags_now.bottom   = (r_now == hm1);
    flags_now.last     = (r_now == hm1) && (c_now == wm1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (c_now == wm1) begin
        col_nxt = '0;
        row_nxt = (r_now == hm1) ? '0 : r_now + 12'd1;
      end else begin
        col_nxt = c_now + CW'(1);
        row_nxt = r_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= cfg_data[10:0];
          CFG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= acc;
      if (s1_valid_r) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= up_rd_r;
        win_r[4] <= md_rd_r;
        win_r[5] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r   <= in_pixel;
      s1_col_r   <= c_now;
      s1_row_r   <= r_now;
      s1_flags_r <= flags_now;
    end
  end

  // line stores: read on accept, written back in the next cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      up_rd_r <= upper_mem[c_now];
      md_rd_r <= middle_mem[c_now];
    end
    if (s1_valid_r) begin
      upper_mem[s1_col_r]  <= md_rd_r;
      middle_mem[s1_col_r] <= s1_pix_r;
    end
  end

  // pixels that cause no result go no further
  assign q_push = s1_valid_r &&
                  (s1_flags_r.main || s1_flags_r.side || s1_flags_r.bottom);

  always_comb begin
    q_item.tl        = win_r[0];
    q_item.ml        = win_r[1];
    q_item.bl        = win_r[2];
    q_item.tm        = win_r[3];
    q_item.bm        = win_r[5];
    q_item.tr        = up_rd_r;
    q_item.mr        = md_rd_r;
    q_item.br        = s1_pix_r;
    q_item.tag.row   = s1_row_r;
    q_item.tag.col   = 10'(s1_col_r);
    q_item.tag.flags = s1_flags_r;
  end

endmodule

// ===== hw/rtl/cg4_queue.sv =====
module cg4_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  cg4_pkg::cg4_item_t      push_item,
  input  logic                    pop,
  output cg4_pkg::cg4_item_t      head_item,
  output logic [cg4_pkg::QCW-1:0] count
);
  import cg4_pkg::*;

  cg4_item_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ((wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ((rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1)) : rd_ptr_r;
    count_nxt  = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

// ===== hw/rtl/cg4_back.sv =====
module cg4_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cg4_pkg::cg4_item_t      head_item,
  input  logic [cg4_pkg::QCW-1:0] q_count,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_magnitude,
  output logic [2:0]              out_direction,
  output logic [9:0]              out_col,
  output logic [11:0]             out_row,
  output logic                    out_frame_last
);
  import cg4_pkg::*;

  // stage A: absolute mask sums
  logic      a_valid_r, a_valid_nxt;
  cg4_grad_t a_grad_r, grad_now;
  cg4_tag_t  a_tag_r;
  // stage B: divided by three
  logic      b_valid_r, b_valid_nxt;
  cg4_quot_t b_quot_r;
  cg4_tag_t  b_tag_r;
  // emit sequencer: one result per cycle from a word while the output is not stalled
  logic [2:0]  pend_r, pend_nxt, pend_low, pend_left;
  logic [7:0]  s_mag_r, best;
  logic [2:0]  s_dir_r, best_dir;
  logic [11:0] s_row_r;
  logic [9:0]  s_col_r;
  logic        s_last_r;
  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_mag_r;
  logic [2:0]  out_dir_r;
  logic [9:0]  out_col_r;
  logic [11:0] out_row_r;
  logic        out_last_r;

  logic q_nonempty, a_ready, b_ready, s_load, out_free, emit;

  always_comb begin
    grad_now.gx = absdiff(sum3(head_item.tr, head_item.mr, head_item.br),
                          sum3(head_item.tl, head_item.ml, head_item.bl));
    grad_now.gd = absdiff(sum3(head_item.tm, head_item.tr, head_item.mr),
                          sum3(head_item.ml, head_item.bl, head_item.bm));
    grad_now.gy = absdiff(sum3(head_item.bl, head_item.bm, head_item.br),
                          sum3(head_item.tl, head_item.tm, head_item.tr));
    grad_now.gi = absdiff(sum3(head_item.mr, head_item.bm, head_item.br),
                          sum3(head_item.tl, head_item.tm, head_item.ml));
  end

  // largest wins, ties go to the earlier direction; without a full window zero, horizontal
  always_comb begin
    best     = b_quot_r.qx;
    best_dir = DIR_HORZ;
    if (b_quot_r.qd > best) begin
      best     = b_quot_r.qd;
      best_dir = DIR_DIAG;
    end
    if (b_quot_r.qy > best) begin
      best     = b_quot_r.qy;
      best_dir = DIR_VERT;
    end
    if (b_quot_r.qi > best) begin
      best     = b_quot_r.qi;
      best_dir = DIR_ANTI;
    end
    if (!b_tag_r.flags.interior) begin
      best     = '0;
      best_dir = DIR_HORZ;
    end
  end

  always_comb begin
    out_free   = !out_valid_r || !out_stall;
    emit       = out_free && (pend_r != '0);
    pend_low   = pend_r & (~pend_r + 3'd1);
    pend_left  = emit ? (pend_r & ~pend_low) : pend_r;
    s_load     = b_valid_r && (pend_left == '0);
    pend_nxt   = s_load ? {b_tag_r.flags.bottom, b_tag_r.flags.side, b_tag_r.flags.main}
                        : pend_left;
    b_ready    = !b_valid_r || s_load;
    a_ready    = !a_valid_r || b_ready;
    q_nonempty = (q_count != '0);
    q_pop      = q_nonempty && a_ready;
    a_valid_nxt   = a_ready ? q_nonempty : a_valid_r;
    b_valid_nxt   = b_ready ? a_valid_r : b_valid_r;
    out_valid_nxt = out_free ? (pend_r != '0) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_grad_r <= grad_now;
      a_tag_r  <= head_item.tag;
    end
    if (b_ready) begin
      b_quot_r.qx <= div3(a_grad_r.gx);
      b_quot_r.qd <= div3(a_grad_r.gd);
      b_quot_r.qy <= div3(a_grad_r.gy);
      b_quot_r.qi <= div3(a_grad_r.gi);
      b_tag_r     <= a_tag_r;
    end
    if (s_load) begin
      s_mag_r  <= best;
      s_dir_r  <= best_dir;
      s_row_r  <= b_tag_r.row;
      s_col_r  <= b_tag_r.col;
      s_last_r <= b_tag_r.flags.last;
    end
    if (emit) begin
      // order: window result, right border, bottom row
      if (pend_r[0]) begin
        out_mag_r  <= s_mag_r;
        out_dir_r  <= s_dir_r;
        out_col_r  <= s_col_r - 10'd1;
        out_row_r  <= s_row_r - 12'd1;
        out_last_r <= 1'b0;
      end else if (pend_r[1]) begin
        out_mag_r  <= '0;
        out_dir_r  <= DIR_HORZ;
        out_col_r  <= s_col_r;
        out_row_r  <= s_row_r - 12'd1;
        out_last_r <= 1'b0;
      end else begin
        out_mag_r  <= '0;
        out_dir_r  <= DIR_HORZ;
        out_col_r  <= s_col_r;
        out_row_r  <= s_row_r;
        out_last_r <= s_last_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_magnitude  = out_mag_r;
  assign out_direction  = out_dir_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_last = out_last_r;

endmodule

// ===== hw/rtl/compass_gradient_4dir_3x3_core.sv =====
// Path: front stage, queue, stage A, stage B, emit sequencer, output register.
// Throughput: 1 pixel per cycle while each pixel yields at most one result and the output
//   is not stalled; pixels in the last column (top row apart) or the last row (first column
//   apart) yield 2-3 words, and the single output register sends one word per cycle.
// Reset: rst_n synchronous, active low; clears position, pipeline and queue state,
//   loads frame_width 640 / frame_height 480. Line stores are not cleared.
module compass_gradient_4dir_3x3_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_magnitude,
  output logic [2:0]  out_direction,
  output logic [9:0]  out_col,
  output logic [11:0] out_row,
  output logic        out_frame_last
);
  import cg4_pkg::*;

  // Front: raster position, two line stores (read on accept, written back the
  // next cycle), the 3x3 window, and classification of which result words a
  // pixel causes. Pixels that cause none are dropped after updating state.
  // Queue: QDEPTH words; the front holds off input using the queue fill plus
  // its one word in flight, so a push is never refused.
  // Back: mask sums -> divide by 3 -> pick max -> sequencer that emits up to
  // three words per queue word into the output register.

  logic           q_push, q_pop;
  cg4_item_t      q_in_item, q_head_item;
  logic [QCW-1:0] q_count;

  // config writes always taken; user keeps the block idle whenever they arrive (unchecked)
  assign cfg_ready = 1'b1;

  cg4_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  cg4_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .count     (q_count)
  );

  cg4_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_item      (q_head_item),
    .q_count        (q_count),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_magnitude  (out_magnitude),
    .out_direction  (out_direction),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== hw/rtl/cg4_chk.sv =====
module cg4_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_magnitude,
  input logic [2:0]  out_direction,
  input logic [11:0] out_row,
  input logic        out_frame_last
);

  // nothing shows right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // last pixel of a frame is a corner, so it is border
  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_magnitude == 8'd0 && out_direction == 3'd0)
    else $error("frame_last word is not zero");

  // top row is border
  a_top_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row == 12'd0 |-> out_magnitude == 8'd0 && out_direction == 3'd0)
    else $error("top row word is not zero");

  // a later direction only wins when strictly larger than a non-negative one
  a_dir_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_direction != 3'd0 |-> out_magnitude != 8'd0)
    else $error("nonzero direction with zero magnitude");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude) &&
      $stable(out_direction) && $stable(out_row) && $stable(out_frame_last))
    else $error("stalled result word changed");

endmodule

bind compass_gradient_4dir_3x3_core cg4_chk u_cg4_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_magnitude  (out_magnitude),
  .out_direction  (out_direction),
  .out_row        (out_row),
  .out_frame_last (out_frame_last)
);
